// ===== sv/dep_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dep_pkg
// Shared codes and types for the double-ended priority queue.
// ----------------------------------------------------------------------------
package dep_pkg;

   // command codes carried on req_tuser
   localparam logic [1:0] CMD_INSERT    = 2'd0;
   localparam logic [1:0] CMD_SERVE_MAX = 2'd1;
   localparam logic [1:0] CMD_SERVE_MIN = 2'd2;

   // status codes carried on rsp_tuser
   localparam logic [1:0] STS_SERVED   = 2'd0;
   localparam logic [1:0] STS_EMPTY    = 2'd1;
   localparam logic [1:0] STS_INSERTED = 2'd2;
   localparam logic [1:0] STS_FULL     = 2'd3;

   // operation broadcast to every cell of the chain
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_POP_MIN,
      CELL_POP_MAX
   } cell_op_type;

   // controller states
   typedef enum logic {
      ST_IDLE,
      ST_WAIT_MAX
   } state_type;

endpackage

// ===== sv/double_ended_priority_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_priority_queue
// Bounded double-ended priority queue built as a sorted chain of cells.
// ----------------------------------------------------------------------------
// Each request is an insert of a (value, priority) pair, a serve of the
// highest priority or a serve of the lowest; every request gives exactly one
// response with the served value, a status and the occupancy afterwards.
// The pairs live in a chain of CAPACITY cells kept sorted by ascending
// priority, lowest at cell 0. Insert and serve-min move the whole chain at
// once. Serve-max reads the tail cell through a registered OR tree of
// log2(CAPACITY) levels, rounded up, and answers once the tree has settled.
// Equal priorities: serve-max returns the latest inserted, serve-min the
// earliest. Inserting into a full queue is dropped and flagged; serving an
// empty queue, or the unused command code, returns value 0 with the empty
// status. The response register decouples the two sides: outside a
// serve-max wait, a new request is taken while the previous response is
// being taken.
// ----------------------------------------------------------------------------
module double_ended_priority_queue
   import dep_pkg::*;
#(
   parameter int CAPACITY      = 256,
   parameter int VALUE_BITS    = 31,
   parameter int PRIORITY_BITS = 31,
   localparam int OCC_W        = $clog2(CAPACITY + 1),
   localparam int REQ_DATA_W   = ((VALUE_BITS + PRIORITY_BITS + 7) / 8) * 8,
   localparam int RSP_DATA_W   = ((VALUE_BITS + OCC_W + 7) / 8) * 8
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // item_value, item_priority, zero pad
   input  logic [1:0]            req_tuser,  // command
   // response channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // served_value, occupancy, zero pad
   output logic [1:0]            rsp_tuser   // status
);

   localparam int LEVELS = $clog2(CAPACITY);
   localparam int LEAVES = 1 << LEVELS;
   localparam int CNT_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;

   // ---- request fields ----
   logic [VALUE_BITS-1:0]    req_value;
   logic [PRIORITY_BITS-1:0] req_priority;
   logic [1:0]               req_command;
   logic                     req_accept;

   assign req_value    = req_tdata[VALUE_BITS-1:0];
   assign req_priority = req_tdata[VALUE_BITS+PRIORITY_BITS-1:VALUE_BITS];
   assign req_command  = req_tuser;
   assign req_accept   = req_tvalid && req_tready;

   // ---- chain of cells ----
   logic                     cell_valid [CAPACITY];
   logic [VALUE_BITS-1:0]    cell_value [CAPACITY];
   logic [PRIORITY_BITS-1:0] cell_prio  [CAPACITY];
   logic                     cell_place [CAPACITY];
   logic                     cell_tail  [CAPACITY];
   logic [VALUE_BITS-1:0]    tree_leaf  [LEAVES];
   logic [VALUE_BITS-1:0]    tree_root;
   cell_op_type              cell_op;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                     l_valid, l_place, r_valid;
      logic [VALUE_BITS-1:0]    l_value, r_value;
      logic [PRIORITY_BITS-1:0] l_prio, r_prio;

      if (i == 0) begin : g_head
         assign l_valid = 1'b0;
         assign l_place = 1'b0;
         assign l_value = '0;
         assign l_prio  = '0;
      end else begin : g_body_l
         assign l_valid = cell_valid[i-1];
         assign l_place = cell_place[i-1];
         assign l_value = cell_value[i-1];
         assign l_prio  = cell_prio[i-1];
      end

      if (i == CAPACITY - 1) begin : g_end
         assign r_valid = 1'b0;
         assign r_value = '0;
         assign r_prio  = '0;
      end else begin : g_body_r
         assign r_valid = cell_valid[i+1];
         assign r_value = cell_value[i+1];
         assign r_prio  = cell_prio[i+1];
      end

      dep_cell #(
         .VALUE_BITS   (VALUE_BITS),
         .PRIORITY_BITS(PRIORITY_BITS)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .op            (cell_op),
         .new_value     (req_value),
         .new_priority  (req_priority),
         .left_valid    (l_valid),
         .left_value    (l_value),
         .left_priority (l_prio),
         .left_place    (l_place),
         .right_valid   (r_valid),
         .right_value   (r_value),
         .right_priority(r_prio),
         .valid         (cell_valid[i]),
         .value         (cell_value[i]),
         .priority_q    (cell_prio[i]),
         .place         (cell_place[i]),
         .tail          (cell_tail[i])
      );
   end

   // only the tail cell feeds a non-zero value into the tree
   for (genvar j = 0; j < LEAVES; j++) begin : g_leaf
      if (j < CAPACITY) begin : g_used
         assign tree_leaf[j] = cell_tail[j] ? cell_value[j] : '0;
      end else begin : g_pad
         assign tree_leaf[j] = '0;
      end
   end

   dep_max_tree #(
      .WIDTH (VALUE_BITS),
      .LEAVES(LEAVES)
   ) u_max_tree (
      .clock(clock),
      .leaf (tree_leaf),
      .root (tree_root)
   );

   // ---- control ----
   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       wait_cnt_ff, wait_cnt_in;
   logic [OCC_W-1:0]       count_ff, count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [VALUE_BITS-1:0]  rsp_value_ff, rsp_value_in;
   logic [1:0]             rsp_status_ff, rsp_status_in;
   logic [OCC_W-1:0]       rsp_occ_ff, rsp_occ_in;
   logic                   rsp_load;
   logic                   q_full, q_empty, wait_done;

   assign q_full    = (count_ff == OCC_W'(CAPACITY));
   assign q_empty   = (count_ff == '0);
   assign wait_done = (wait_cnt_ff == '0);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && req_command == CMD_SERVE_MAX && !q_empty) begin
               state_in = ST_WAIT_MAX;
            end
         end
         ST_WAIT_MAX: begin
            if (wait_done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the controller
   always_comb begin
      req_tready    = 1'b0;
      cell_op       = CELL_HOLD;
      rsp_load      = 1'b0;
      rsp_value_in  = '0;
      rsp_status_in = STS_EMPTY;
      count_in      = count_ff;
      wait_cnt_in   = wait_cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            req_tready  = !rsp_valid_ff || rsp_tready;
            wait_cnt_in = CNT_W'(LEVELS - 1);
            if (req_accept) begin
               rsp_load = 1'b1;
               case (req_command)
                  CMD_INSERT: begin
                     if (q_full) begin
                        rsp_status_in = STS_FULL;
                     end else begin
                        cell_op       = CELL_INSERT;
                        rsp_status_in = STS_INSERTED;
                        count_in      = count_ff + 1'b1;
                     end
                  end
                  CMD_SERVE_MIN: begin
                     if (!q_empty) begin
                        cell_op       = CELL_POP_MIN;
                        rsp_value_in  = cell_value[0];
                        rsp_status_in = STS_SERVED;
                        count_in      = count_ff - 1'b1;
                     end
                  end
                  CMD_SERVE_MAX: begin
                     // answered once the tree has settled
                     if (!q_empty) begin
                        rsp_load = 1'b0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_WAIT_MAX: begin
            wait_cnt_in = wait_cnt_ff - 1'b1;
            if (wait_done) begin
               cell_op       = CELL_POP_MAX;
               rsp_load      = 1'b1;
               rsp_value_in  = tree_root;
               rsp_status_in = STS_SERVED;
               count_in      = count_ff - 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_occ_in   = count_in;
   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wait_cnt_ff <= wait_cnt_in;
      if (rsp_load) begin
         rsp_value_ff  <= rsp_value_in;
         rsp_status_ff <= rsp_status_in;
         rsp_occ_ff    <= rsp_occ_in;
      end
   end

   // ---- response ----
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_occ_ff, rsp_value_ff});

endmodule

// ===== sv/dep_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dep_cell
// One slot of the sorted chain: holds a pair, shifts with its neighbours.
// ----------------------------------------------------------------------------
module dep_cell
   import dep_pkg::*;
#(
   parameter int VALUE_BITS    = 31,
   parameter int PRIORITY_BITS = 31
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cell_op_type              op,
   input  logic [VALUE_BITS-1:0]    new_value,
   input  logic [PRIORITY_BITS-1:0] new_priority,
   input  logic                     left_valid,
   input  logic [VALUE_BITS-1:0]    left_value,
   input  logic [PRIORITY_BITS-1:0] left_priority,
   input  logic                     left_place,
   input  logic                     right_valid,
   input  logic [VALUE_BITS-1:0]    right_value,
   input  logic [PRIORITY_BITS-1:0] right_priority,
   output logic                     valid,
   output logic [VALUE_BITS-1:0]    value,
   output logic [PRIORITY_BITS-1:0] priority_q,
   output logic                     place,
   output logic                     tail
);

   logic                     valid_ff, valid_in;
   logic [VALUE_BITS-1:0]    value_ff, value_in;
   logic [PRIORITY_BITS-1:0] prio_ff, prio_in;

   // new pair lands here or further left; equal priorities stay in front
   assign place = !valid_ff || (prio_ff > new_priority);
   assign tail  = valid_ff && !right_valid;

   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      prio_in  = prio_ff;
      case (op)
         CELL_INSERT: begin
            if (left_place) begin
               valid_in = left_valid;
               value_in = left_value;
               prio_in  = left_priority;
            end else if (place) begin
               valid_in = 1'b1;
               value_in = new_value;
               prio_in  = new_priority;
            end
         end
         CELL_POP_MIN: begin
            valid_in = right_valid;
            value_in = right_value;
            prio_in  = right_priority;
         end
         CELL_POP_MAX: begin
            if (tail) begin
               valid_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      prio_ff  <= prio_in;
   end

   assign valid      = valid_ff;
   assign value      = value_ff;
   assign priority_q = prio_ff;

endmodule

// ===== sv/dep_max_tree.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dep_max_tree
// Registered OR tree gathering the value of the tail cell, one level a cycle.
// ----------------------------------------------------------------------------
module dep_max_tree #(
   parameter int WIDTH  = 31,
   parameter int LEAVES = 256
) (
   input  logic             clock,
   input  logic [WIDTH-1:0] leaf [LEAVES],
   output logic [WIDTH-1:0] root
);

   // heap layout: node k combines 2k and 2k+1; leaves sit at LEAVES..2*LEAVES-1
   logic [WIDTH-1:0] node_ff [1:LEAVES-1];

   for (genvar k = 1; k < LEAVES; k++) begin : g_node
      if (2 * k >= LEAVES) begin : g_leaf
         always_ff @(posedge clock) begin
            node_ff[k] <= leaf[2*k-LEAVES] | leaf[2*k+1-LEAVES];
         end
      end else begin : g_inner
         always_ff @(posedge clock) begin
            node_ff[k] <= node_ff[2*k] | node_ff[2*k+1];
         end
      end
   end

   assign root = node_ff[1];

endmodule

// ===== sim/double_ended_priority_queue_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_priority_queue_tb
// Self-checking bench for the double-ended priority queue.
// ----------------------------------------------------------------------------
// Sends insert, serve-max, serve-min and the unused command code down the
// request stream. Every response is checked against a sorted shadow copy of
// the queue, kept in ascending priority order.
// A short directed opening covers the empty queue, extreme values and
// priority ties at both ends. Random phases follow: a fill past capacity,
// a drain past empty, then bursts biased towards filling, draining or
// neither. Both stream sides idle in random bursts. One long response
// hold-off backs the block up into its request side.
// ----------------------------------------------------------------------------
module double_ended_priority_queue_tb;
   import dep_pkg::*;

   localparam int CAPACITY = 256;
   localparam int VALUE_W  = 31;
   localparam int PRIO_W   = 31;
   localparam int OCC_W    = 9;
   localparam int REQ_W    = 64;   // value + priority, padded to bytes
   localparam int RSP_W    = 40;   // served value + occupancy, padded to bytes

   // code 3 has no name in the package; the block treats it as a no-op
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam int RANDOM_ITEMS = 1400;
   localparam int CALM_TAIL    = 150;     // last requests go without idling
   localparam int HOLD_AT      = 420;     // responses taken before the hold-off
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 30;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int MAX_PRINTS   = 40;

   localparam logic [VALUE_W-1:0] VALUE_MAX = '1;
   localparam logic [PRIO_W-1:0]  PRIO_MAX  = '1;

   typedef struct packed {
      logic [1:0]         cmd;
      logic [VALUE_W-1:0] value;
      logic [PRIO_W-1:0]  prio;
   } request_type;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [PRIO_W-1:0]  prio;
   } pair_type;

   typedef struct packed {
      logic [VALUE_W-1:0] served;
      logic [1:0]         status;
      logic [OCC_W-1:0]   occupancy;
   } response_type;

   // ------------------------------------------------------------------------
   // DUT ports
   // ------------------------------------------------------------------------
   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata  = '0;          // item_value, item_priority, zero pad
   logic [1:0]       req_tuser  = CMD_INSERT;  // command
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;                // served_value, occupancy
   logic [1:0]       rsp_tuser;                // status

   double_ended_priority_queue #(
      .CAPACITY      (CAPACITY),
      .VALUE_BITS    (VALUE_W),
      .PRIORITY_BITS (PRIO_W)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Bench state
   // ------------------------------------------------------------------------
   request_type  req_backlog[$];   // requests not yet offered
   response_type due_rsp[$];       // responses owed, oldest first
   pair_type     shadow[$];        // held pairs, ascending priority

   int errors     = 0;
   int rsp_taken  = 0;
   int cycles     = 0;
   int n_insert   = 0;
   int n_full     = 0;
   int n_max      = 0;
   int n_min      = 0;
   int n_empty    = 0;
   int peak_occ   = 0;

   task automatic report_mismatch(input string what);
      errors++;
      if (errors <= MAX_PRINTS)
         $display("ERROR @%0t rsp #%0d: %s", $time, rsp_taken, what);
   endtask

   // Applies one accepted request to the shadow queue; returns the response
   // the block owes for it.
   function automatic response_type run_command(input request_type r);
      response_type res;
      pair_type     pair;
      int           pos;
      res        = '0;
      res.status = STS_EMPTY;
      case (r.cmd)
         CMD_INSERT: begin
            if (shadow.size() >= CAPACITY) begin
               res.status = STS_FULL;
               n_full++;
            end else begin
               // new pair goes after every entry of lower or equal priority
               pos = shadow.size();
               while (pos > 0 && shadow[pos-1].prio > r.prio)
                  pos--;
               pair.value = r.value;
               pair.prio  = r.prio;
               shadow.insert(pos, pair);
               res.status = STS_INSERTED;
               n_insert++;
            end
         end
         CMD_SERVE_MAX, CMD_SERVE_MIN: begin
            if (shadow.size() == 0) begin
               n_empty++;
            end else begin
               if (r.cmd == CMD_SERVE_MAX) begin
                  pair = shadow.pop_back();
                  n_max++;
               end else begin
                  pair = shadow.pop_front();
                  n_min++;
               end
               res.served = pair.value;
               res.status = STS_SERVED;
            end
         end
         default: n_empty++;   // unused code: nothing served
      endcase
      res.occupancy = OCC_W'(shadow.size());
      if (shadow.size() > peak_occ)
         peak_occ = shadow.size();
      return res;
   endfunction

   task automatic check_response(input logic [RSP_W-1:0] data, input logic [1:0] sts);
      response_type       want;
      logic [VALUE_W-1:0] got_value;
      logic [OCC_W-1:0]   got_occ;
      got_value = data[VALUE_W-1:0];
      got_occ   = data[VALUE_W +: OCC_W];
      if (due_rsp.size() == 0) begin
         report_mismatch("response with no request outstanding");
      end else begin
         want = due_rsp.pop_front();
         if (got_value !== want.served)
            report_mismatch($sformatf("served_value %0h, want %0h", got_value, want.served));
         if (sts !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", sts, want.status));
         if (got_occ !== want.occupancy)
            report_mismatch($sformatf("occupancy %0d, want %0d", got_occ, want.occupancy));
      end
   endtask

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   function automatic void queue_request(input logic [1:0] cmd,
                                         input logic [VALUE_W-1:0] value,
                                         input logic [PRIO_W-1:0] prio);
      request_type r;
      r.cmd   = cmd;
      r.value = value;
      r.prio  = prio;
      req_backlog.push_back(r);
   endfunction

   function automatic logic [VALUE_W-1:0] pick_value();
      logic [31:0] raw;
      raw = $urandom();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return VALUE_MAX;
         default: return raw[VALUE_W-1:0];
      endcase
   endfunction

   // mix of wide spread, narrow spread and a handful of values to force ties
   function automatic logic [PRIO_W-1:0] pick_prio();
      logic [31:0] raw;
      raw = $urandom();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return raw[PRIO_W-1:0];
         4, 5:       return PRIO_W'($urandom_range(0, 7));
         6:          return $urandom_range(0, 1) ? PRIO_MAX : '0;
         default:    return PRIO_W'($urandom_range(0, 1023));
      endcase
   endfunction

   function automatic void queue_serve();
      queue_request($urandom_range(0, 1) ? CMD_SERVE_MAX : CMD_SERVE_MIN,
                    pick_value(), pick_prio());
   endfunction

   function automatic void queue_random(input int insert_pct);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 2)
         queue_request(CMD_UNUSED, pick_value(), pick_prio());
      else if (roll < insert_pct)
         queue_request(CMD_INSERT, pick_value(), pick_prio());
      else
         queue_serve();
   endfunction

   initial begin : stimulus
      int total;
      int span;
      int bias;
      // empty queue on both serves and the unused code, data bits all high, all low, then all high
      queue_request(CMD_SERVE_MAX, VALUE_MAX, PRIO_MAX);
      queue_request(CMD_SERVE_MIN, '0, '0);
      queue_request(CMD_UNUSED, VALUE_MAX, PRIO_MAX);
      // extremes, with a tie at each end of the priority range
      queue_request(CMD_INSERT, VALUE_MAX, PRIO_MAX);
      queue_request(CMD_INSERT, '0, '0);
      queue_request(CMD_INSERT, 31'h2AAAAAAA, '0);
      queue_request(CMD_INSERT, 31'h55555555, PRIO_MAX);
      queue_request(CMD_INSERT, 31'h1, 31'h40000000);
      queue_request(CMD_INSERT, 31'h7, 31'h3FFFFFFF);
      queue_request(CMD_UNUSED, '0, '0);         // no-op on a held queue
      queue_request(CMD_SERVE_MAX, '0, '0);      // latest of the top tie
      queue_request(CMD_SERVE_MIN, '0, '0);      // earliest of the bottom tie
      queue_request(CMD_SERVE_MAX, '0, '0);
      queue_request(CMD_SERVE_MIN, '0, '0);
      queue_request(CMD_SERVE_MIN, '0, '0);
      queue_request(CMD_SERVE_MAX, '0, '0);
      queue_request(CMD_SERVE_MAX, '0, '0);      // empty again
      // three-way tie in the middle, served from both ends
      queue_request(CMD_INSERT, 31'd5, 31'd9);
      queue_request(CMD_INSERT, 31'd6, 31'd9);
      queue_request(CMD_INSERT, 31'd7, 31'd9);
      queue_request(CMD_SERVE_MIN, '0, '0);
      queue_request(CMD_SERVE_MAX, '0, '0);
      queue_request(CMD_SERVE_MIN, '0, '0);

      // fill past capacity, then drain past empty
      for (int i = 0; i < CAPACITY + 12; i++)
         queue_request(CMD_INSERT, pick_value(), pick_prio());
      for (int i = 0; i < CAPACITY + 12; i++)
         queue_serve();
      total = 2 * (CAPACITY + 12);

      // bursts that lean towards filling, draining or neither
      while (total < RANDOM_ITEMS) begin
         case ($urandom_range(0, 2))
            0:       bias = 50;
            1:       bias = 85;
            default: bias = 15;
         endcase
         span = $urandom_range(20, 120);
         for (int i = 0; i < span; i++)
            queue_random(bias);
         total += span;
      end
   end

   // ------------------------------------------------------------------------
   // Request driver: holds each request until taken, idles in bursts
   // ------------------------------------------------------------------------
   int          gap_left = 0;
   request_type offered;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            due_rsp.push_back(run_command(offered));
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (req_backlog.size() == 0) begin
               req_tvalid <= 1'b0;
            end else if (req_backlog.size() > CALM_TAIL && $urandom_range(0, 11) == 0) begin
               gap_left = $urandom_range(0, 10);   // start a burst of idle cycles
               req_tvalid <= 1'b0;
            end else begin
               offered = req_backlog.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {{(REQ_W - VALUE_W - PRIO_W){1'b0}}, offered.prio, offered.value};
               req_tuser  <= offered.cmd;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Long hold-off on the response side, once, so the block backs up
   // ------------------------------------------------------------------------
   int hold_left = 0;
   bit hold_done = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (!hold_done && rsp_taken >= HOLD_AT) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // ------------------------------------------------------------------------
   // Response monitor: checks every taken response, stalls in bursts
   // ------------------------------------------------------------------------
   int stall_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            check_response(rsp_tdata, rsp_tuser);
            rsp_taken <= rsp_taken + 1;
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (req_backlog.size() > CALM_TAIL && $urandom_range(0, 11) == 0) begin
            stall_left = $urandom_range(0, 10);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Watchdog
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycles, due_rsp.size());
         $display("double_ended_priority_queue: mismatch");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Reset, end of run and verdict
   // ------------------------------------------------------------------------
   initial begin : control
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      while (req_backlog.size() != 0 || req_tvalid)
         @(negedge clock);
      while (due_rsp.size() != 0)
         @(negedge clock);
      // anything arriving now has no request behind it and is flagged
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("run: %0d inserts, %0d dropped on full, %0d served max, %0d served min",
               n_insert, n_full, n_max, n_min);
      $display("run: %0d empty or unused requests, peak occupancy %0d of %0d, %0d responses",
               n_empty, peak_occ, CAPACITY, rsp_taken);
      if (errors == 0)
         $display("double_ended_priority_queue: match");
      else
         $display("double_ended_priority_queue: mismatch");
      $finish;
   end

endmodule
